FILE: rtl/draw_without_replacement_macros.svh
// Assertion macros shared by the draw_without_replacement RTL.
`ifndef DRAW_WITHOUT_REPLACEMENT_MACROS_SVH
`define DRAW_WITHOUT_REPLACEMENT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define DWR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define DWR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define DWR_ASSERT_NOW(label, ante, cons)

`define DWR_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: rtl/dwr_pkg.sv
// Package with sizes and codes of the draw_without_replacement block.
package dwr_pkg;

    localparam int POOL_SIZE = 256;
    localparam int POOL_AW   = $clog2(POOL_SIZE);
    localparam int CNT_W     = POOL_AW + 1;
    localparam int CFG_W     = 9;
    localparam int VAL_W     = 8;
    localparam int FRAC_W    = 16;
    localparam int PROD_W    = CNT_W + FRAC_W;
    localparam int STEP_W    = $clog2(CNT_W);
    localparam int CFG_RESET = 256;

    typedef enum logic
    {
        OP_DRAW    = 1'b0,
        OP_RESTART = 1'b1
    } opcode_t;

endpackage

FILE: rtl/draw_without_replacement.sv
// Draw without replacement: incremental shuffle over a pool of numbers.
// A draw runs from acceptance to the result word in steps: 9 shift-add steps of the
// shared adder form the position, then two pool reads, one write and the output load.
// A restart, and a draw with nothing remaining, go straight to the output load; it waits
// while a result is held unaccepted; the next word is taken in the cycle after it loads.
// rst_n clears all control state at once; per-entry valid bits make every pool entry read
// as its own index after reset or restart, and active_size resets to 256.
`include "draw_without_replacement_macros.svh"

module draw_without_replacement
    import dwr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_wdata,   // active_size
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [FRAC_W-1:0] s_tdata,     // random_fraction
    input  logic              s_tuser,     // opcode
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [VAL_W-1:0]  m_tdata,     // drawn_value
    output logic              m_tuser      // exhausted
);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_MUL,
        ST_RD_POS,
        ST_RD_LAST,
        ST_WRITE,
        ST_DONE
    } state_t;

    state_t                 state_reg;
    logic [CFG_W-1:0]       active_size_reg;
    logic [CNT_W-1:0]       remaining_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [PROD_W-1:0]      prod_next;
    logic [FRAC_W-1:0]      frac_reg;
    logic [STEP_W-1:0]      step_reg;
    logic [POOL_SIZE-1:0]   valid_reg;
    logic [VAL_W-1:0]       res_value_reg;
    logic                   res_exh_reg;
    logic                   m_tvalid_reg;
    logic [VAL_W-1:0]       m_tdata_reg;
    logic                   m_tuser_reg;

    logic [VAL_W-1:0]       pool_mem [POOL_SIZE];
    logic [VAL_W-1:0]       rd_data_reg;
    logic                   rd_valid_reg;
    logic [POOL_AW-1:0]     rd_addr_reg;
    logic [POOL_AW-1:0]     rd_addr;
    logic [VAL_W-1:0]       rd_word;
    logic [POOL_AW-1:0]     pos;
    logic [POOL_AW-1:0]     last;
    logic [FRAC_W:0]        sum;
    logic [CNT_W-1:0]       eff_size;
    logic                   pool_we;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign eff_size = (int'(active_size_reg) > POOL_SIZE) ? CNT_W'(POOL_SIZE)
                                                           : CNT_W'(active_size_reg);

    assign sum = {1'b0, prod_reg[PROD_W-1:CNT_W]}
               + (prod_reg[0] ? {1'b0, frac_reg} : {(FRAC_W + 1){1'b0}});
    assign prod_next = {sum, prod_reg[CNT_W-1:1]};

    assign pos     = prod_reg[FRAC_W +: POOL_AW];
    assign last    = POOL_AW'(remaining_reg - CNT_W'(1));
    assign rd_addr = (state_reg == ST_RD_POS) ? pos : last;
    assign rd_word = rd_valid_reg ? rd_data_reg : VAL_W'(rd_addr_reg);
    assign pool_we = (state_reg == ST_WRITE);

    always_ff @(posedge clk)
    begin
        if (pool_we)
        begin
            pool_mem[pos] <= rd_word;
        end
        rd_data_reg  <= pool_mem[rd_addr];
        rd_valid_reg <= valid_reg[rd_addr];
        rd_addr_reg  <= rd_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            active_size_reg <= CFG_W'(CFG_RESET);
            remaining_reg   <= (CFG_RESET > POOL_SIZE) ? CNT_W'(POOL_SIZE)
                                                       : CNT_W'(CFG_RESET);
            valid_reg       <= '0;
            step_reg        <= '0;
            prod_reg        <= '0;
            frac_reg        <= '0;
            res_value_reg   <= '0;
            res_exh_reg     <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            m_tdata_reg     <= '0;
            m_tuser_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                active_size_reg <= cfg_wdata;
            end
            if (m_tvalid_reg && m_tready && (state_reg != ST_DONE))
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        if (opcode_t'(s_tuser) == OP_RESTART)
                        begin
                            valid_reg     <= '0;
                            remaining_reg <= eff_size;
                            res_value_reg <= '0;
                            res_exh_reg   <= 1'b0;
                            state_reg     <= ST_DONE;
                        end
                        else if (remaining_reg == '0)
                        begin
                            res_value_reg <= '0;
                            res_exh_reg   <= 1'b1;
                            state_reg     <= ST_DONE;
                        end
                        else
                        begin
                            prod_reg  <= {{FRAC_W{1'b0}}, remaining_reg};
                            frac_reg  <= s_tdata;
                            step_reg  <= '0;
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_MUL:
                begin
                    prod_reg <= prod_next;
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(CNT_W - 1))
                    begin
                        state_reg <= ST_RD_POS;
                    end
                end
                ST_RD_POS:
                begin
                    state_reg <= ST_RD_LAST;
                end
                ST_RD_LAST:
                begin
                    res_value_reg <= rd_word;
                    state_reg     <= ST_WRITE;
                end
                ST_WRITE:
                begin
                    valid_reg[pos] <= 1'b1;
                    remaining_reg  <= remaining_reg - CNT_W'(1);
                    res_exh_reg    <= 1'b0;
                    state_reg      <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= res_value_reg;
                        m_tuser_reg  <= res_exh_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `DWR_ASSERT_NOW(a_remaining_bound, 1'b1, int'(remaining_reg) <= POOL_SIZE)
    `DWR_ASSERT_NOW(a_pos_below_remaining, state_reg == ST_RD_POS, CNT_W'(pos) < remaining_reg)
    `DWR_ASSERT_NOW(a_exhausted_zero, m_tvalid && m_tuser, m_tdata == '0)
    `DWR_ASSERT_NEXT(a_remaining_held, state_reg == ST_MUL, $stable(remaining_reg))
    `DWR_ASSERT_NEXT(a_write_consumes, state_reg == ST_WRITE,
                     remaining_reg == $past(remaining_reg) - CNT_W'(1))

endmodule

FILE: tb/draw_without_replacement_test.sv
// Self-checking stream testbench for draw_without_replacement: directed table plus random draws.
module draw_without_replacement_test;
    import dwr_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_COUNT    = 12;
    localparam int PHASE_WORDS    = 42;

    typedef enum logic
    {
        ROW_WORD,
        ROW_CFG
    } row_kind_t;

    typedef struct packed
    {
        logic [VAL_W-1:0] value;
        logic             exhausted;
    } draw_result_t;

    typedef struct packed
    {
        row_kind_t         kind;
        opcode_t           op;
        logic [FRAC_W-1:0] data;
        logic              checked;
        logic [VAL_W-1:0]  exp_value;
        logic              exp_exhausted;
    } stim_row_t;

    localparam int ROW_COUNT = 25;

    stim_row_t directed_rows [0:ROW_COUNT-1] = '{
        '{ROW_WORD, OP_DRAW,    16'h0000, 1'b1, 8'd0,   1'b0},
        '{ROW_WORD, OP_DRAW,    16'hFFFF, 1'b1, 8'd254, 1'b0},
        '{ROW_WORD, OP_DRAW,    16'h0000, 1'b1, 8'd255, 1'b0},
        '{ROW_WORD, OP_DRAW,    16'hAAAA, 1'b0, 8'd0,   1'b0},
        '{ROW_WORD, OP_DRAW,    16'h5555, 1'b0, 8'd0,   1'b0},
        '{ROW_WORD, OP_RESTART, 16'h0000, 1'b1, 8'd0,   1'b0},
        '{ROW_WORD, OP_DRAW,    16'h8000, 1'b1, 8'd128, 1'b0},
        '{ROW_CFG,  OP_DRAW,    16'd0,    1'b0, 8'd0,   1'b0},
        '{ROW_WORD, OP_DRAW,    16'h1234, 1'b0, 8'd0,   1'b0},
        '{ROW_WORD, OP_RESTART, 16'hFFFF, 1'b1, 8'd0,   1'b0},
        '{ROW_WORD, OP_DRAW,    16'hFFFF, 1'b1, 8'd0,   1'b1},
        '{ROW_WORD, OP_DRAW,    16'h0000, 1'b1, 8'd0,   1'b1},
        '{ROW_CFG,  OP_DRAW,    16'd1,    1'b0, 8'd0,   1'b0},
        '{ROW_WORD, OP_RESTART, 16'h0000, 1'b1, 8'd0,   1'b0},
        '{ROW_WORD, OP_DRAW,    16'hFFFF, 1'b1, 8'd0,   1'b0},
        '{ROW_WORD, OP_DRAW,    16'h8000, 1'b1, 8'd0,   1'b1},
        '{ROW_CFG,  OP_DRAW,    16'd511,  1'b0, 8'd0,   1'b0},
        '{ROW_WORD, OP_RESTART, 16'h0000, 1'b1, 8'd0,   1'b0},
        '{ROW_WORD, OP_DRAW,    16'hFFFF, 1'b1, 8'd255, 1'b0},
        '{ROW_CFG,  OP_DRAW,    16'd2,    1'b0, 8'd0,   1'b0},
        '{ROW_WORD, OP_RESTART, 16'h0000, 1'b1, 8'd0,   1'b0},
        '{ROW_WORD, OP_DRAW,    16'hFFFF, 1'b1, 8'd1,   1'b0},
        '{ROW_WORD, OP_DRAW,    16'hFFFF, 1'b1, 8'd0,   1'b0},
        '{ROW_WORD, OP_DRAW,    16'h0000, 1'b1, 8'd0,   1'b1},
        '{ROW_WORD, OP_RESTART, 16'h0000, 1'b1, 8'd0,   1'b0}
    };

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [CFG_W-1:0]  cfg_wdata;
    logic              s_tvalid;
    logic              s_tready;
    logic [FRAC_W-1:0] s_tdata;
    logic              s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [VAL_W-1:0]  m_tdata;
    logic              m_tuser;

    logic [VAL_W-1:0]  pool_model [0:POOL_SIZE-1];
    logic [CFG_W-1:0]  size_model;
    logic [CFG_W-1:0]  left_model;

    draw_result_t      pending_draws [$];
    int                mismatch_count;
    int                send_idle_pct;
    int                recv_idle_pct;
    int                stall_cycles;
    int                hold_left;
    bit                hold_request;

    draw_without_replacement dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void refill_pool();
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            pool_model[i] = i[VAL_W-1:0];
        end
        left_model = (size_model > POOL_SIZE) ? CFG_W'(POOL_SIZE) : size_model;
    endfunction

    function automatic draw_result_t shuffle_draw(opcode_t op, logic [FRAC_W-1:0] frac);
        draw_result_t            res;
        logic [CFG_W+FRAC_W-1:0] product;
        logic [CFG_W-1:0]        pos;
        res = '0;
        if (op == OP_RESTART)
        begin
            refill_pool();
        end
        else if (left_model == '0)
        begin
            res.exhausted = 1'b1;
        end
        else
        begin
            product = left_model * frac;
            pos = product[CFG_W+FRAC_W-1:FRAC_W];
            res.value = pool_model[pos];
            pool_model[pos] = pool_model[left_model - 1'b1];
            left_model = left_model - 1'b1;
        end
        return res;
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    task automatic send_word(opcode_t op, logic [FRAC_W-1:0] frac, bit checked,
                             draw_result_t typed);
        draw_result_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= frac;
        do
            @(posedge clk);
        while (!s_tready);
        predicted = shuffle_draw(op, frac);
        pending_draws.push_back(checked ? typed : predicted);
    endtask

    task automatic drain_draws();
        s_tvalid <= 1'b0;
        while (pending_draws.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_size(logic [CFG_W-1:0] size);
        drain_draws();
        cfg_we    <= 1'b1;
        cfg_wdata <= size;
        @(posedge clk);
        cfg_we    <= 1'b0;
        size_model = size;
    endtask

    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        draw_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_draws.size() == 0)
            begin
                flag_mismatch("unexpected word, drawn_value", m_tdata, -1);
            end
            else
            begin
                want = pending_draws.pop_front();
                if (m_tdata !== want.value)
                begin
                    flag_mismatch("drawn_value", m_tdata, want.value);
                end
                if (m_tuser !== want.exhausted)
                begin
                    flag_mismatch("exhausted", m_tuser, want.exhausted);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !rst_n)
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        logic [CFG_W-1:0]  size;
        opcode_t           op;
        draw_result_t      typed;
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_wdata      <= '0;
        s_tvalid       <= 1'b0;
        s_tdata        <= '0;
        s_tuser        <= 1'b0;
        m_tready       <= 1'b0;
        mismatch_count = 0;
        stall_cycles   = 0;
        hold_left      = 0;
        hold_request   = 1'b0;
        send_idle_pct  = 32;
        recv_idle_pct  = 50;
        size_model     = CFG_W'(CFG_RESET);
        refill_pool();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < ROW_COUNT; r++)
        begin
            if (directed_rows[r].kind == ROW_CFG)
            begin
                write_size(directed_rows[r].data[CFG_W-1:0]);
            end
            else
            begin
                typed.value     = directed_rows[r].exp_value;
                typed.exhausted = directed_rows[r].exp_exhausted;
                send_word(directed_rows[r].op, directed_rows[r].data,
                          directed_rows[r].checked, typed);
            end
        end

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0: size = 9'd256;
                1: size = 9'd511;
                2: size = 9'd0;
                3: size = 9'd1;
                default:
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        size = CFG_W'($urandom_range(0, 511));
                    end
                    else
                    begin
                        size = CFG_W'($urandom_range(1, 40));
                    end
                end
            endcase
            write_size(size);
            if (phase < 4)
            begin
                send_idle_pct = 32;
                recv_idle_pct = 50;
            end
            else if (phase < 8)
            begin
                send_idle_pct = 50;
                recv_idle_pct = 32;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (phase == 8)
            begin
                hold_request = 1'b1;
            end
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if (n == 0)
                begin
                    op = ($urandom_range(0, 9) != 0) ? OP_RESTART : OP_DRAW;
                end
                else
                begin
                    op = ($urandom_range(0, 24) == 0) ? OP_RESTART : OP_DRAW;
                end
                send_word(op, FRAC_W'($urandom_range(0, 65535)), 1'b0, '0);
            end
        end

        drain_draws();
        if (mismatch_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/dwr_pkg.sv
rtl/draw_without_replacement.sv
tb/draw_without_replacement_test.sv
